[design/mvt_pkg.sv]
package mvt_pkg;

   localparam int ROW_COUNT = 4;
   localparam int VEC_LEN = 4;
   localparam int COEF_W = 16;
   localparam int COMP_W = 32;
   localparam int ROW_W = COEF_W * VEC_LEN;
   localparam int IDX_W = $clog2(ROW_COUNT);
   localparam int PROD_W = COEF_W + COMP_W;
   localparam int PAIR_W = PROD_W + 1;
   localparam int SUM_W = PAIR_W + 2;
   localparam int FRAC_SHIFT = 12;
   localparam int SHIFT_W = SUM_W - FRAC_SHIFT;
   localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_SHIFT);
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (FRAC_SHIFT - 1));
   localparam logic signed [COMP_W-1:0] OUT_MAX = {1'b0, {(COMP_W-1){1'b1}}};
   localparam logic signed [COMP_W-1:0] OUT_MIN = {1'b1, {(COMP_W-1){1'b0}}};

   typedef logic [ROW_W-1:0] row_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [PAIR_W-1:0] pair_type;
   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic signed [SHIFT_W-1:0] shift_type;

   function automatic row_type row_reset(input int i);
      row_type r;
      r = '0;
      r[i*COEF_W +: COEF_W] = COEF_ONE;
      return r;
   endfunction

   function automatic coef_type row_coef(input row_type row, input int j);
      return coef_type'(row[j*COEF_W +: COEF_W]);
   endfunction

endpackage

[design/mvt_ifs.sv]
interface mvt_req_if import mvt_pkg::*; ();
   logic valid;
   logic ready;
   comp_type x_in;
   comp_type y_in;
   comp_type z_in;
   comp_type w_in;

   modport source (output valid, output x_in, output y_in, output z_in, output w_in,
                   input ready);
   modport sink (input valid, input x_in, input y_in, input z_in, input w_in,
                 output ready);
endinterface

interface mvt_rsp_if import mvt_pkg::*; ();
   logic valid;
   logic ready;
   comp_type x_out;
   comp_type y_out;
   comp_type z_out;
   comp_type w_out;
   logic saturated;

   modport source (output valid, output x_out, output y_out, output z_out, output w_out,
                   output saturated, input ready);
   modport sink (input valid, input x_out, input y_out, input z_out, input w_out,
                 input saturated, output ready);
endinterface

[design/mvt_mul.sv]
module mvt_mul import mvt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  comp_type vec[VEC_LEN],
   input  row_type  rows[ROW_COUNT],
   output logic     out_valid,
   input  logic     out_ready,
   output prod_type prod[ROW_COUNT][VEC_LEN]
);

   logic     valid_ff;
   prod_type prod_ff[ROW_COUNT][VEC_LEN];
   prod_type prod_in[ROW_COUNT][VEC_LEN];

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign prod = prod_ff;

   always_comb begin
      for (int i = 0; i < ROW_COUNT; i++) begin
         for (int j = 0; j < VEC_LEN; j++) begin
            prod_in[i][j] = prod_type'(row_coef(rows[i], j)) * prod_type'(vec[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_ff <= prod_in;
      end
   end

endmodule

[design/mvt_add.sv]
module mvt_add import mvt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  prod_type prod[ROW_COUNT][VEC_LEN],
   output logic     out_valid,
   input  logic     out_ready,
   output sum_type  sum[ROW_COUNT]
);

   localparam int PAIRS = VEC_LEN / 2;

   logic     pair_valid_ff;
   logic     sum_valid_ff;
   logic     pair_ready;
   logic     sum_ready;
   pair_type pair_ff[ROW_COUNT][PAIRS];
   pair_type pair_in[ROW_COUNT][PAIRS];
   sum_type  sum_ff[ROW_COUNT];
   sum_type  sum_in[ROW_COUNT];

   assign sum_ready = !sum_valid_ff || out_ready;
   assign pair_ready = !pair_valid_ff || sum_ready;
   assign in_ready = pair_ready;
   assign out_valid = sum_valid_ff;
   assign sum = sum_ff;

   // pair sums, then row sum with rounding bias
   always_comb begin
      for (int i = 0; i < ROW_COUNT; i++) begin
         for (int k = 0; k < PAIRS; k++) begin
            pair_in[i][k] = pair_type'(prod[i][2*k]) + pair_type'(prod[i][2*k+1]);
         end
      end
      for (int i = 0; i < ROW_COUNT; i++) begin
         sum_in[i] = ROUND_HALF;
         for (int k = 0; k < PAIRS; k++) begin
            sum_in[i] = sum_in[i] + sum_type'(pair_ff[i][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         if (pair_ready) begin
            pair_valid_ff <= in_valid;
         end
         if (sum_ready) begin
            sum_valid_ff <= pair_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pair_ready && in_valid) begin
         pair_ff <= pair_in;
      end
      if (sum_ready && pair_valid_ff) begin
         sum_ff <= sum_in;
      end
   end

endmodule

[design/mvt_sat.sv]
module mvt_sat import mvt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  sum_type  sum[ROW_COUNT],
   output logic     out_valid,
   input  logic     out_ready,
   output comp_type res[ROW_COUNT],
   output logic     saturated
);

   logic      valid_ff;
   comp_type  res_ff[ROW_COUNT];
   comp_type  res_in[ROW_COUNT];
   logic      sat_ff;
   logic      sat_in;
   shift_type shifted;
   logic      over;

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign res = res_ff;
   assign saturated = sat_ff;

   always_comb begin
      sat_in = 1'b0;
      shifted = '0;
      over = 1'b0;
      for (int i = 0; i < ROW_COUNT; i++) begin
         shifted = shift_type'(sum[i] >>> FRAC_SHIFT);
         // upper bits must all match the sign of the 32-bit result
         over = !((&shifted[SHIFT_W-1:COMP_W-1]) || !(|shifted[SHIFT_W-1:COMP_W-1]));
         if (over) begin
            res_in[i] = shifted[SHIFT_W-1] ? OUT_MIN : OUT_MAX;
         end else begin
            res_in[i] = shifted[COMP_W-1:0];
         end
         sat_in = sat_in | over;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

endmodule

[design/matrix_vector_transform_core.sv]
// throughput: one item per cycle while rsp_if.ready holds, four register
// stages (multiply, pair add, row add with rounding, shift and saturate),
// each stalls only when full
// reset: synchronous, clears all stage valid bits and loads the identity matrix
module matrix_vector_transform_core import mvt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mvt_req_if.sink   req_if,
   mvt_rsp_if.source rsp_if,
   input  logic      csr_we,
   input  idx_type   csr_index,
   input  row_type   csr_wdata
);

   row_type  row_ff[ROW_COUNT];
   comp_type vec[VEC_LEN];
   prod_type prod[ROW_COUNT][VEC_LEN];
   sum_type  sum[ROW_COUNT];
   comp_type res[ROW_COUNT];
   logic     mul_valid;
   logic     mul_ready;
   logic     add_valid;
   logic     add_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROW_COUNT; i++) begin
            row_ff[i] <= row_reset(i);
         end
      end else if (csr_we) begin
         row_ff[csr_index] <= csr_wdata;
      end
   end

   assign vec[0] = req_if.x_in;
   assign vec[1] = req_if.y_in;
   assign vec[2] = req_if.z_in;
   assign vec[3] = req_if.w_in;

   mvt_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .vec       (vec),
      .rows      (row_ff),
      .out_valid (mul_valid),
      .out_ready (mul_ready),
      .prod      (prod)
   );

   mvt_add u_add (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (mul_ready),
      .prod      (prod),
      .out_valid (add_valid),
      .out_ready (add_ready),
      .sum       (sum)
   );

   mvt_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (add_valid),
      .in_ready  (add_ready),
      .sum       (sum),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .res       (res),
      .saturated (rsp_if.saturated)
   );

   assign rsp_if.x_out = res[0];
   assign rsp_if.y_out = res[1];
   assign rsp_if.z_out = res[2];
   assign rsp_if.w_out = res[3];

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import mvt_pkg::*;

   typedef struct {
      comp_type x;
      comp_type y;
      comp_type z;
      comp_type w;
      logic     sat;
   } vec_result_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    csr_we;
   idx_type csr_index;
   row_type csr_wdata;

   mvt_req_if req_if ();
   mvt_rsp_if rsp_if ();

   matrix_vector_transform_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   row_type        matrix_rows[ROW_COUNT];
   vec_result_type expected_results[$];
   bit             throttle_on = 1'b1;
   int             ready_hold = 0;
   int             mismatches = 0;
   int             vectors_sent = 0;
   int             results_seen = 0;
   int             saturated_seen = 0;
   int             matrix_loads = 0;

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("timeout: %0d items sent, %0d results seen", vectors_sent, results_seen);
      $display("RESULT: ERROR");
      $finish;
   end

   // fixed-point transform of one vector by the current matrix
   function automatic vec_result_type transform_vec(input comp_type v[VEC_LEN]);
      vec_result_type r;
      comp_type       comp[ROW_COUNT];
      longint         acc;
      longint         rnd;
      r.sat = 1'b0;
      for (int i = 0; i < ROW_COUNT; i++) begin
         acc = 0;
         for (int j = 0; j < VEC_LEN; j++) begin
            acc += longint'(coef_type'(matrix_rows[i][j*COEF_W +: COEF_W])) * longint'(v[j]);
         end
         rnd = (acc + longint'(ROUND_HALF)) >>> FRAC_SHIFT;
         if (rnd > longint'(OUT_MAX)) begin
            comp[i] = OUT_MAX;
            r.sat = 1'b1;
         end else if (rnd < longint'(OUT_MIN)) begin
            comp[i] = OUT_MIN;
            r.sat = 1'b1;
         end else begin
            comp[i] = comp_type'(rnd);
         end
      end
      r.x = comp[0];
      r.y = comp[1];
      r.z = comp[2];
      r.w = comp[3];
      return r;
   endfunction

   function automatic row_type pack_row(input coef_type c0, c1, c2, c3);
      return {c3, c2, c1, c0};
   endfunction

   // mostly short gaps, a few long ones
   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (!throttle_on || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic comp_type random_comp();
      case ($urandom_range(0, 9))
         0: return OUT_MAX;
         1: return OUT_MIN;
         2: return comp_type'($urandom_range(0, 2)) - comp_type'(1);
         3, 4: return comp_type'($urandom_range(0, 32'h000F_FFFF)) - comp_type'(32'h0008_0000);
         default: return comp_type'($urandom);
      endcase
   endfunction

   function automatic coef_type random_coef();
      case ($urandom_range(0, 9))
         0: return coef_type'(COEF_ONE);
         1: return coef_type'(16'h8000);
         2: return coef_type'(16'h7FFF);
         3: return coef_type'(16'hFFFF);
         4: return coef_type'(0);
         5, 6: return coef_type'($urandom_range(0, 8191)) - coef_type'(4096);
         default: return coef_type'($urandom);
      endcase
   endfunction

   function automatic void check_field(input string label, input logic [COMP_W-1:0] want,
                                       input logic [COMP_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on result %0d, %s: expected %h, got %h",
                     results_seen, label, want, got);
      end
   endfunction

   // result side: random backpressure
   always @(negedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (throttle_on && $urandom_range(0, 3) == 0) begin
         rsp_if.ready <= 1'b0;
         ready_hold <= 1 + idle_cycles();
      end else begin
         rsp_if.ready <= 1'b1;
         ready_hold <= throttle_on ? $urandom_range(0, 5) : 0;
      end
   end

   always @(posedge clock) begin
      vec_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: %h %h %h %h sat %b", rsp_if.x_out, rsp_if.y_out,
                        rsp_if.z_out, rsp_if.w_out, rsp_if.saturated);
         end else begin
            want = expected_results.pop_front();
            check_field("x_out", want.x, rsp_if.x_out);
            check_field("y_out", want.y, rsp_if.y_out);
            check_field("z_out", want.z, rsp_if.z_out);
            check_field("w_out", want.w, rsp_if.w_out);
            check_field("saturated", COMP_W'(want.sat), COMP_W'(rsp_if.saturated));
            if (want.sat) saturated_seen++;
         end
         results_seen++;
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_vec(input comp_type x, y, z, w);
      comp_type v[VEC_LEN];
      int       gap;
      v[0] = x;
      v[1] = y;
      v[2] = z;
      v[3] = w;
      gap = idle_cycles();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.x_in <= x;
      req_if.y_in <= y;
      req_if.z_in <= z;
      req_if.w_in <= w;
      do @(posedge clock); while (!req_if.ready);
      expected_results.push_back(transform_vec(v));
      vectors_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      int waited;
      waited = 0;
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      if (expected_results.size() != 0) begin
         mismatches += expected_results.size();
         $display("%0d expected items never arrived", expected_results.size());
         expected_results.delete();
      end
   endtask

   task automatic load_matrix(input row_type r0, r1, r2, r3);
      row_type rows[ROW_COUNT];
      rows[0] = r0;
      rows[1] = r1;
      rows[2] = r2;
      rows[3] = r3;
      for (int i = 0; i < ROW_COUNT; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx_type'(i);
         csr_wdata <= rows[i];
         @(negedge clock);
         matrix_rows[i] = rows[i];
      end
      csr_we <= 1'b0;
      matrix_loads++;
   endtask

   task automatic test_identity_passthrough();
      send_vec('0, '0, '0, '0);
      send_vec(OUT_MAX, OUT_MAX, OUT_MAX, OUT_MAX);
      send_vec(OUT_MIN, OUT_MIN, OUT_MIN, OUT_MIN);
      send_vec(comp_type'(-1), comp_type'(1), comp_type'(-1), comp_type'(1));
      send_vec(OUT_MAX, OUT_MIN, '0, comp_type'(32'h0001_0000));
      send_vec(comp_type'(32'h5555_5555), comp_type'(32'hAAAA_AAAA),
               comp_type'(32'h1234_5678), comp_type'(32'h8765_4321));
      settle();
   endtask

   // exact halves go toward plus infinity
   task automatic test_rounding_ties();
      load_matrix(pack_row(16'h0001, 16'h0000, 16'h0000, 16'h0000),
                  pack_row(16'h0000, 16'h0800, 16'h0000, 16'h0000),
                  pack_row(16'h0000, 16'h0000, 16'hFFFF, 16'h0000),
                  pack_row(16'h0001, 16'h0000, 16'h0000, 16'h0001));
      send_vec(comp_type'(2048), comp_type'(1), comp_type'(2048), '0);
      send_vec(comp_type'(-2048), comp_type'(-1), comp_type'(-2048), '0);
      send_vec(comp_type'(2047), comp_type'(3), comp_type'(2049), comp_type'(1));
      send_vec(comp_type'(-2049), comp_type'(-3), comp_type'(-2047), comp_type'(-1));
      send_vec(OUT_MAX, OUT_MAX, OUT_MIN, OUT_MAX);
      settle();
   endtask

   task automatic test_saturation();
      load_matrix({4{16'h7FFF}}, {4{16'h8000}},
                  pack_row(16'h8000, 16'h7FFF, 16'h0000, 16'h0000), '0);
      send_vec(OUT_MAX, OUT_MAX, OUT_MAX, OUT_MAX);
      send_vec(OUT_MIN, OUT_MIN, OUT_MIN, OUT_MIN);
      send_vec(OUT_MAX, OUT_MIN, '0, '0);
      send_vec(OUT_MIN, OUT_MAX, OUT_MAX, OUT_MIN);
      send_vec(comp_type'(1), comp_type'(1), comp_type'(1), comp_type'(1));
      settle();
   endtask

   task automatic test_random_transforms();
      row_type r[ROW_COUNT];
      for (int p = 0; p < 8; p++) begin
         for (int i = 0; i < ROW_COUNT; i++) begin
            case (p)
               0: r[i] = '0;
               1: r[i] = '1;
               2: r[i] = {4{16'h8000}};
               3: r[i] = {4{16'h7FFF}};
               default: r[i] = pack_row(random_coef(), random_coef(), random_coef(),
                                        random_coef());
            endcase
         end
         throttle_on = (p % 3) != 2;
         load_matrix(r[0], r[1], r[2], r[3]);
         repeat (200) send_vec(random_comp(), random_comp(), random_comp(), random_comp());
         settle();
      end
      throttle_on = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.x_in = '0;
      req_if.y_in = '0;
      req_if.z_in = '0;
      req_if.w_in = '0;
      rsp_if.ready = 1'b0;
      for (int i = 0; i < ROW_COUNT; i++)
         matrix_rows[i] = row_type'(COEF_ONE) << (COEF_W * i);
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_identity_passthrough();
      test_rounding_ties();
      test_saturation();
      test_random_transforms();

      repeat (10) @(negedge clock);
      $display("transformed %0d vectors under %0d matrix loads plus the reset matrix",
               vectors_sent, matrix_loads);
      $display("%0d results checked, %0d of them clamped, %0d mismatches",
               results_seen, saturated_seen, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
